// ===== rtl/ftm_pkg.sv =====
package ftm_pkg;

   localparam int unsigned REQ_DATA_W = 144;
   localparam int unsigned RSP_DATA_W = 448;

   localparam logic [31:0] RATE_RESET = 32'd32985;
   localparam logic signed [30:0] NS_PER_SEC = 31'sd1000000000;
   localparam logic [47:0] ALL_ONES_48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] ALL_ONES_32 = 32'hFFFF_FFFF;

   localparam logic [1:0] KIND_OPEN   = 2'd0;
   localparam logic [1:0] KIND_FRAME  = 2'd1;
   localparam logic [1:0] KIND_REPORT = 2'd2;

   typedef struct packed {
      logic        func;
      logic [47:0] arrival;
      logic [31:0] sec;
      logic [29:0] nanosec;
      logic [31:0] payload;
   } req_item_type;

   typedef struct packed {
      logic        func;
      logic [47:0] arrival;
      logic [31:0] payload;
      logic [63:0] stamp;
   } stamp_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        was_open;
      logic [47:0] arrival;
      logic [31:0] payload;
      logic [63:0] stamp;
      logic        hdr_pos;
      logic [47:0] hdr_gap;
      logic [62:0] hdr_dt;
   } hdr_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        was_open;
      logic [47:0] arrival;
      logic [31:0] payload;
      logic [63:0] stamp;
      logic        hdr_pos;
      logic [47:0] hdr_gap;
      logic [63:0] prod_lo;
      logic [62:0] prod_hi;
   } prod_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        was_open;
      logic [47:0] arrival;
      logic [31:0] payload;
      logic [63:0] stamp;
      logic        hdr_pos;
      logic [47:0] hdr_gap;
      logic [31:0] missing_add;
   } acc_item_type;

   // The last member sits in the lowest bits of the result bus.
   typedef struct packed {
      logic [31:0] out_of_order_count;
      logic [31:0] missing_frames;
      logic [47:0] max_header_gap;
      logic [47:0] min_header_gap;
      logic [47:0] max_arrival_gap;
      logic [47:0] min_arrival_gap;
      logic [63:0] header_span_ns;
      logic [47:0] arrival_span_ns;
      logic [47:0] byte_total;
      logic [31:0] frame_count;
   } rsp_data_type;

endpackage

// ===== rtl/ftm_stamp.sv =====
module ftm_stamp
   import ftm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  req_item_type   in_item,
   output logic           out_valid,
   input  logic           out_ready,
   output stamp_item_type out_item
);

   logic           cap_valid_ff, cap_valid_in;
   req_item_type   cap_item_ff, cap_item_in;
   logic           stamp_valid_ff, stamp_valid_in;
   stamp_item_type stamp_item_ff, stamp_item_in;
   logic           cap_ready;
   logic           stamp_ready;
   logic signed [62:0] sec_prod;

   assign stamp_ready = !stamp_valid_ff || out_ready;
   assign cap_ready   = !cap_valid_ff || stamp_ready;
   assign in_ready    = cap_ready;
   assign sec_prod    = 63'($signed(cap_item_ff.sec)) * 63'(NS_PER_SEC);

   always_comb begin
      cap_valid_in   = cap_ready ? in_valid : cap_valid_ff;
      cap_item_in    = (cap_ready && in_valid) ? in_item : cap_item_ff;
      stamp_valid_in = stamp_ready ? cap_valid_ff : stamp_valid_ff;
      stamp_item_in  = stamp_item_ff;
      if (stamp_ready && cap_valid_ff) begin
         stamp_item_in.func    = cap_item_ff.func;
         stamp_item_in.arrival = cap_item_ff.arrival;
         stamp_item_in.payload = cap_item_ff.payload;
         stamp_item_in.stamp   = {sec_prod[62], sec_prod} + {34'd0, cap_item_ff.nanosec};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_valid_ff   <= 1'b0;
         stamp_valid_ff <= 1'b0;
      end else begin
         cap_valid_ff   <= cap_valid_in;
         stamp_valid_ff <= stamp_valid_in;
      end
      cap_item_ff   <= cap_item_in;
      stamp_item_ff <= stamp_item_in;
   end

   assign out_valid = stamp_valid_ff;
   assign out_item  = stamp_item_ff;

endmodule

// ===== rtl/ftm_interval.sv =====
module ftm_interval
   import ftm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  stamp_item_type in_item,
   output logic           out_valid,
   input  logic           out_ready,
   output hdr_item_type   out_item
);

   logic         window_open_ff, window_open_in;
   logic [63:0]  prev_header_ff, prev_header_in;
   logic         hdr_valid_ff, hdr_valid_in;
   hdr_item_type hdr_item_ff, hdr_item_in;
   logic         take;
   logic [63:0]  hdt;

   assign in_ready = !hdr_valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign hdt      = in_item.stamp - prev_header_ff;

   always_comb begin
      window_open_in = window_open_ff;
      prev_header_in = prev_header_ff;
      hdr_valid_in   = in_ready ? in_valid : hdr_valid_ff;
      hdr_item_in    = hdr_item_ff;
      if (take) begin
         hdr_item_in.was_open = window_open_ff;
         hdr_item_in.arrival  = in_item.arrival;
         hdr_item_in.payload  = in_item.payload;
         hdr_item_in.stamp    = in_item.stamp;
         hdr_item_in.hdr_pos  = !hdt[63] && (hdt != 64'd0);
         hdr_item_in.hdr_gap  = (|hdt[62:48]) ? ALL_ONES_48 : hdt[47:0];
         hdr_item_in.hdr_dt   = hdt[62:0];
         if (in_item.func) begin
            hdr_item_in.kind = KIND_REPORT;
            window_open_in   = 1'b0;
         end else begin
            hdr_item_in.kind = window_open_ff ? KIND_FRAME : KIND_OPEN;
            window_open_in   = 1'b1;
            prev_header_in   = in_item.stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_open_ff <= 1'b0;
         prev_header_ff <= 64'd0;
         hdr_valid_ff   <= 1'b0;
      end else begin
         window_open_ff <= window_open_in;
         prev_header_ff <= prev_header_in;
         hdr_valid_ff   <= hdr_valid_in;
      end
      hdr_item_ff <= hdr_item_in;
   end

   assign out_valid = hdr_valid_ff;
   assign out_item  = hdr_item_ff;

endmodule

// ===== rtl/ftm_periods.sv =====
module ftm_periods
   import ftm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [31:0]  rate,
   input  logic         in_valid,
   output logic         in_ready,
   input  hdr_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output acc_item_type out_item
);

   localparam logic [95:0] ROUND_HALF = 96'd1 << 39;

   logic          prod_valid_ff, prod_valid_in;
   prod_item_type prod_item_ff, prod_item_in;
   logic          acc_valid_ff, acc_valid_in;
   acc_item_type  acc_item_ff, acc_item_in;
   logic          prod_ready;
   logic          acc_ready;
   logic [63:0]   lo_prod;
   logic [62:0]   hi_prod;
   logic [95:0]   scaled;
   logic [55:0]   periods;
   logic [55:0]   extra;
   logic [31:0]   add_amount;

   assign acc_ready  = !acc_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || acc_ready;
   assign in_ready   = prod_ready;

   assign lo_prod = 64'(in_item.hdr_dt[31:0]) * 64'(rate);
   assign hi_prod = 63'(in_item.hdr_dt[62:32]) * 63'(rate);

   assign scaled  = {32'd0, prod_item_ff.prod_lo} + {1'b0, prod_item_ff.prod_hi, 32'd0}
                    + ROUND_HALF;
   assign periods = scaled[95:40];
   assign extra   = periods - 56'd1;

   always_comb begin
      add_amount = 32'd0;
      if (prod_item_ff.hdr_pos && (|periods[55:1])) begin
         add_amount = (|extra[55:32]) ? ALL_ONES_32 : extra[31:0];
      end
   end

   always_comb begin
      prod_valid_in = prod_ready ? in_valid : prod_valid_ff;
      prod_item_in  = prod_item_ff;
      if (prod_ready && in_valid) begin
         prod_item_in.kind     = in_item.kind;
         prod_item_in.was_open = in_item.was_open;
         prod_item_in.arrival  = in_item.arrival;
         prod_item_in.payload  = in_item.payload;
         prod_item_in.stamp    = in_item.stamp;
         prod_item_in.hdr_pos  = in_item.hdr_pos;
         prod_item_in.hdr_gap  = in_item.hdr_gap;
         prod_item_in.prod_lo  = lo_prod;
         prod_item_in.prod_hi  = hi_prod;
      end
      acc_valid_in = acc_ready ? prod_valid_ff : acc_valid_ff;
      acc_item_in  = acc_item_ff;
      if (acc_ready && prod_valid_ff) begin
         acc_item_in.kind        = prod_item_ff.kind;
         acc_item_in.was_open    = prod_item_ff.was_open;
         acc_item_in.arrival     = prod_item_ff.arrival;
         acc_item_in.payload     = prod_item_ff.payload;
         acc_item_in.stamp       = prod_item_ff.stamp;
         acc_item_in.hdr_pos     = prod_item_ff.hdr_pos;
         acc_item_in.hdr_gap     = prod_item_ff.hdr_gap;
         acc_item_in.missing_add = add_amount;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         acc_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         acc_valid_ff  <= acc_valid_in;
      end
      prod_item_ff <= prod_item_in;
      acc_item_ff  <= acc_item_in;
   end

   assign out_valid = acc_valid_ff;
   assign out_item  = acc_item_ff;

endmodule

// ===== rtl/ftm_window.sv =====
module ftm_window
   import ftm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  acc_item_type in_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_report_valid,
   output rsp_data_type rsp_data
);

   logic [31:0]  count_ff, count_in;
   logic [47:0]  bytes_ff, bytes_in;
   logic [47:0]  first_arrival_ff, first_arrival_in;
   logic [47:0]  prev_arrival_ff, prev_arrival_in;
   logic [63:0]  first_header_ff, first_header_in;
   logic [63:0]  last_header_ff, last_header_in;
   logic [47:0]  min_arr_gap_ff, min_arr_gap_in;
   logic [47:0]  max_arr_gap_ff, max_arr_gap_in;
   logic [47:0]  min_hdr_gap_ff, min_hdr_gap_in;
   logic [47:0]  max_hdr_gap_ff, max_hdr_gap_in;
   logic [31:0]  missing_ff, missing_in;
   logic [31:0]  nonmono_ff, nonmono_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_report_valid_ff, rsp_report_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   logic         out_free;
   logic         is_report;
   logic         take;
   logic         report_ok;
   logic [47:0]  arr_gap;
   logic [48:0]  bytes_sum;
   logic [32:0]  missing_sum;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign is_report   = in_item.kind == KIND_REPORT;
   assign in_ready    = !is_report || out_free;
   assign take        = in_valid && in_ready;
   assign report_ok   = in_item.was_open && (|count_ff[31:1]);
   assign arr_gap     = in_item.arrival - prev_arrival_ff;
   assign bytes_sum   = {1'b0, bytes_ff} + {17'd0, in_item.payload};
   assign missing_sum = {1'b0, missing_ff} + {1'b0, in_item.missing_add};

   always_comb begin
      count_in            = count_ff;
      bytes_in            = bytes_ff;
      first_arrival_in    = first_arrival_ff;
      prev_arrival_in     = prev_arrival_ff;
      first_header_in     = first_header_ff;
      last_header_in      = last_header_ff;
      min_arr_gap_in      = min_arr_gap_ff;
      max_arr_gap_in      = max_arr_gap_ff;
      min_hdr_gap_in      = min_hdr_gap_ff;
      max_hdr_gap_in      = max_hdr_gap_ff;
      missing_in          = missing_ff;
      nonmono_in          = nonmono_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_report_valid_in = rsp_report_valid_ff;
      rsp_data_in         = rsp_data_ff;
      if (take) begin
         case (in_item.kind)
            KIND_OPEN: begin
               count_in         = 32'd1;
               bytes_in         = {16'd0, in_item.payload};
               first_arrival_in = in_item.arrival;
               prev_arrival_in  = in_item.arrival;
               first_header_in  = in_item.stamp;
               last_header_in   = in_item.stamp;
               min_arr_gap_in   = ALL_ONES_48;
               max_arr_gap_in   = 48'd0;
               min_hdr_gap_in   = ALL_ONES_48;
               max_hdr_gap_in   = 48'd0;
               missing_in       = 32'd0;
               nonmono_in       = 32'd0;
            end
            KIND_FRAME: begin
               if (arr_gap < min_arr_gap_ff) begin
                  min_arr_gap_in = arr_gap;
               end
               if (arr_gap > max_arr_gap_ff) begin
                  max_arr_gap_in = arr_gap;
               end
               if (in_item.hdr_pos) begin
                  if (in_item.hdr_gap < min_hdr_gap_ff) begin
                     min_hdr_gap_in = in_item.hdr_gap;
                  end
                  if (in_item.hdr_gap > max_hdr_gap_ff) begin
                     max_hdr_gap_in = in_item.hdr_gap;
                  end
                  missing_in = (missing_sum >= {1'b0, ALL_ONES_32}) ? ALL_ONES_32
                                                                    : missing_sum[31:0];
               end else if (nonmono_ff != ALL_ONES_32) begin
                  nonmono_in = nonmono_ff + 32'd1;
               end
               if (count_ff != ALL_ONES_32) begin
                  count_in = count_ff + 32'd1;
               end
               bytes_in        = (bytes_sum >= {1'b0, ALL_ONES_48}) ? ALL_ONES_48
                                                                    : bytes_sum[47:0];
               prev_arrival_in = in_item.arrival;
               last_header_in  = in_item.stamp;
            end
            KIND_REPORT: begin
               rsp_valid_in        = 1'b1;
               rsp_report_valid_in = report_ok;
               rsp_data_in         = '0;
               if (report_ok) begin
                  rsp_data_in.frame_count        = count_ff;
                  rsp_data_in.byte_total         = bytes_ff;
                  rsp_data_in.arrival_span_ns    = prev_arrival_ff - first_arrival_ff;
                  rsp_data_in.header_span_ns     = last_header_ff - first_header_ff;
                  rsp_data_in.min_arrival_gap    = min_arr_gap_ff;
                  rsp_data_in.max_arrival_gap    = max_arr_gap_ff;
                  rsp_data_in.min_header_gap     = min_hdr_gap_ff;
                  rsp_data_in.max_header_gap     = max_hdr_gap_ff;
                  rsp_data_in.missing_frames     = missing_ff;
                  rsp_data_in.out_of_order_count = nonmono_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= 32'd0;
         bytes_ff         <= 48'd0;
         first_arrival_ff <= 48'd0;
         prev_arrival_ff  <= 48'd0;
         first_header_ff  <= 64'd0;
         last_header_ff   <= 64'd0;
         min_arr_gap_ff   <= ALL_ONES_48;
         max_arr_gap_ff   <= 48'd0;
         min_hdr_gap_ff   <= ALL_ONES_48;
         max_hdr_gap_ff   <= 48'd0;
         missing_ff       <= 32'd0;
         nonmono_ff       <= 32'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         count_ff         <= count_in;
         bytes_ff         <= bytes_in;
         first_arrival_ff <= first_arrival_in;
         prev_arrival_ff  <= prev_arrival_in;
         first_header_ff  <= first_header_in;
         last_header_ff   <= last_header_in;
         min_arr_gap_ff   <= min_arr_gap_in;
         max_arr_gap_ff   <= max_arr_gap_in;
         min_hdr_gap_ff   <= min_hdr_gap_in;
         max_hdr_gap_ff   <= max_hdr_gap_in;
         missing_ff       <= missing_in;
         nonmono_ff       <= nonmono_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_report_valid_ff <= rsp_report_valid_in;
      rsp_data_ff         <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_report_valid = rsp_report_valid_ff;
   assign rsp_data         = rsp_data_ff;

`ifndef SYNTH
   a_valid_needs_two: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_report_valid_ff) |-> (rsp_data_ff.frame_count >= 32'd2))
      else $error("A valid report shows fewer than two frames.");

   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_report_valid_ff) |-> (rsp_data_ff == '0))
      else $error("An empty report carries non-zero statistics.");

   a_gap_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_report_valid_ff)
      |-> (rsp_data_ff.min_arrival_gap <= rsp_data_ff.max_arrival_gap))
      else $error("The minimum arrival gap exceeds the maximum.");

   a_report_shown: assert property (@(posedge clock) disable iff (reset)
      (take && is_report) |=> rsp_valid_ff)
      else $error("A report item did not reach the result register.");
`endif

endmodule

// ===== rtl/frame_timing_monitor.sv =====
// Up to five items are held in flight, one in each pipeline register ahead of the result register.
// Throughput: one item per cycle unless a report stalls; frame items pass the final stage
// without using the output. A waiting result stalls the next report and all items behind it.
// The stages are the header stamp multiplier, the interval stage, a split 63 by 32 bit
// period multiplier with its rounding add, and the window accumulators with the result register.
// Synchronous reset empties the pipeline, closes the window and restores the rate register.
module frame_timing_monitor
   import ftm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // arrival_time_ns, header_sec, header_nanosec, payload_bytes, zero padding
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // frame_count, byte_total, arrival_span_ns, header_span_ns, min_arrival_gap,
   // max_arrival_gap, min_header_gap, max_header_gap, missing_frames, out_of_order_count
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // report_valid
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [31:0]           csr_data
);

   logic [31:0]    rate_ff, rate_in;
   req_item_type   req_item;
   logic           stamp_valid, stamp_ready;
   stamp_item_type stamp_item;
   logic           hdr_valid, hdr_ready;
   hdr_item_type   hdr_item;
   logic           acc_valid, acc_ready;
   acc_item_type   acc_item;
   rsp_data_type   rsp_data;

   assign csr_ready = 1'b1;
   assign rate_in   = csr_valid ? csr_data : rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else begin
         rate_ff <= rate_in;
      end
   end

   assign req_item.func    = req_tuser;
   assign req_item.arrival = req_tdata[47:0];
   assign req_item.sec     = req_tdata[79:48];
   assign req_item.nanosec = req_tdata[109:80];
   assign req_item.payload = req_tdata[141:110];

   ftm_stamp u_stamp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (stamp_valid),
      .out_ready (stamp_ready),
      .out_item  (stamp_item)
   );

   ftm_interval u_interval (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stamp_valid),
      .in_ready  (stamp_ready),
      .in_item   (stamp_item),
      .out_valid (hdr_valid),
      .out_ready (hdr_ready),
      .out_item  (hdr_item)
   );

   ftm_periods u_periods (
      .clock     (clock),
      .reset     (reset),
      .rate      (rate_ff),
      .in_valid  (hdr_valid),
      .in_ready  (hdr_ready),
      .in_item   (hdr_item),
      .out_valid (acc_valid),
      .out_ready (acc_ready),
      .out_item  (acc_item)
   );

   ftm_window u_window (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (acc_valid),
      .in_ready         (acc_ready),
      .in_item          (acc_item),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_report_valid (rsp_tuser),
      .rsp_data         (rsp_data)
   );

   assign rsp_tdata = rsp_data;

endmodule
